/* hdl/esc_pkg.sv */
package esc_pkg;

    // Building and table dimensions.
    localparam int FLOORS      = 32;
    localparam int ELEVATORS   = 8;
    localparam int TABLE_SLOTS = 64;

    // Register reset values and limits.
    localparam logic [3:0] CAP_LIMIT = 4'd8;
    localparam logic [3:0] CAP_RESET = 4'd4;
    localparam logic [5:0] FIU_RESET = 6'd32;

    // Command codes carried on the input tuser.
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TURN     = 1'b1;

    // Configuration register indexes.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_FLOORS   = 1'b1;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_DROP = 2'd0;
    localparam logic [1:0] KIND_PICK = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    // Direction codes.
    localparam logic [1:0] MOVE_STAY = 2'd0;
    localparam logic [1:0] MOVE_UP   = 2'd1;
    localparam logic [1:0] MOVE_DOWN = 2'd2;

    // One request slot as stored in the table memory.
    typedef struct packed {
        logic [15:0] order;
        logic        aboard;
        logic [2:0]  car;
        logic [4:0]  target;
        logic [4:0]  origin;
        logic [15:0] ident;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REG_SCAN,
        ST_FULL_OUT,
        ST_DROP_SCAN,
        ST_DROP_OUT,
        ST_PICK_CHECK,
        ST_PICK_SCAN,
        ST_PICK_OUT,
        ST_DIR_SCAN,
        ST_DIR_OUT
    } state_t;

endpackage

/* hdl/esc_ram.sv */
module esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/elevator_stop_scheduler.sv */
// Stop scheduler for a group of elevators. A register transfer (tuser = 0) stores a waiting
// request in the lowest free table slot and returns nothing unless the table is full. A turn
// transfer (tuser = 1) drops riders bound for the current floor, picks waiters there up to
// capacity and ends with a direction result that carries tlast. The drop, pick and direction
// searches run through one compare unit fed by the single read port of the slot memory, one
// slot per cycle. Back-pressure on the result stream stalls the block in its result states.
// The block takes a new transfer only when the previous one is done.
module elevator_stop_scheduler
    import esc_pkg::*;
#(
    parameter int TABLE_SLOTS = esc_pkg::TABLE_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] request_id, [20:16] start_floor, [25:21] end_floor, [28:26] elevator,
    // [33:29] current_floor, [39:34] zero.
    input  logic [39:0] s_tdata,
    // [0] command.
    input  logic        s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] passenger_id, [18:16] elevator_number, [20:19] move, [23:21] zero.
    output logic [23:0] m_tdata,
    // [1:0] result_kind.
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SLOT_END = CW'(TABLE_SLOTS);

    // Control state.
    state_t              state_reg, state_next;
    logic [3:0]          capacity_reg, capacity_next;
    logic [5:0]          fiu_reg, fiu_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [15:0]         oc_reg, oc_next;
    logic [3:0]          load_reg [ELEVATORS];
    logic [3:0]          load_next [ELEVATORS];
    logic [1:0]          heading_reg [ELEVATORS];
    logic [1:0]          heading_next [ELEVATORS];
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                found_reg, found_next;
    logic                up_found_reg, up_found_next;
    logic                dn_found_reg, dn_found_next;
    logic                full_reg, full_next;
    logic [4:0]          nres_reg, nres_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Payload state.
    logic [15:0]         id_reg, id_next;
    logic [4:0]          sf_reg, sf_next;
    logic [4:0]          ef_reg, ef_next;
    logic [2:0]          car_reg, car_next;
    logic [4:0]          cur_reg, cur_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    slot_t               best_slot_reg, best_slot_next;
    logic [15:0]         best_age_reg, best_age_next;
    logic [4:0]          up_d_reg, up_d_next;
    logic [4:0]          dn_d_reg, dn_d_next;
    logic [1:0]          m_kind_reg, m_kind_next;
    logic [15:0]         m_id_reg, m_id_next;
    logic [2:0]          m_elev_reg, m_elev_next;
    logic [1:0]          m_move_reg, m_move_next;
    logic                m_last_reg, m_last_next;

    // Memory ports.
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    slot_t               ram_wdata;
    logic [SLOT_W-1:0]   ram_rdata;
    slot_t               rd_slot;

    // Shared compare unit signals.
    logic                out_free;
    logic                issuing;
    logic                scan_done;
    logic                start_scan;
    logic [3:0]          cap_eff;
    logic [5:0]          lim;
    logic [3:0]          car_load;
    logic                hit_car;
    logic                want_aboard;
    logic                sel_match;
    logic [15:0]         age;
    logic                better;
    logic [4:0]          cand_f;
    logic                cand_ok;
    logic                cand_up;
    logic                cand_dn;
    logic [4:0]          cand_up_d;
    logic [4:0]          cand_dn_d;
    logic [1:0]          new_heading;

    esc_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(scan_cnt_reg[IW-1:0]),
        .rd_data(ram_rdata)
    );

    assign rd_slot  = slot_t'(ram_rdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_move_reg, m_elev_reg, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // Effective limits and the served car's load.
    assign cap_eff  = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign lim      = (fiu_reg > 6'(FLOORS)) ? 6'(FLOORS) : fiu_reg;
    assign car_load = load_reg[car_reg];
    assign out_free = !m_tvalid_reg || m_tready;
    assign issuing  = (scan_cnt_reg < SLOT_END);
    assign scan_done = !issuing && !rd_pend_reg;

    // Compare unit: evaluates the slot returned by the memory this cycle.
    assign hit_car     = valid_reg[rd_idx_reg] && (rd_slot.car == car_reg);
    assign want_aboard = (state_reg == ST_DROP_SCAN);
    assign sel_match   = hit_car && (rd_slot.aboard == want_aboard) &&
                         ((want_aboard ? rd_slot.target : rd_slot.origin) == cur_reg);
    assign age         = oc_reg - rd_slot.order;
    assign better      = sel_match && (!found_reg || (age < best_age_reg));
    assign cand_f      = rd_slot.aboard ? rd_slot.target : rd_slot.origin;
    assign cand_ok     = hit_car && (rd_slot.aboard || !full_reg);
    assign cand_up     = cand_ok && (cand_f > cur_reg) && ({1'b0, cand_f} < lim);
    assign cand_dn     = cand_ok && (cand_f < cur_reg);
    assign cand_up_d   = cand_f - cur_reg;
    assign cand_dn_d   = cur_reg - cand_f;

    // Heading choice at the end of a turn.
    always_comb begin
        if (!up_found_reg && !dn_found_reg) begin
            new_heading = MOVE_STAY;
        end else if (up_found_reg && !dn_found_reg) begin
            new_heading = MOVE_UP;
        end else if (!up_found_reg && dn_found_reg) begin
            new_heading = MOVE_DOWN;
        end else if (heading_reg[car_reg] == MOVE_UP || heading_reg[car_reg] == MOVE_DOWN) begin
            new_heading = heading_reg[car_reg];
        end else begin
            new_heading = (up_d_reg <= dn_d_reg) ? MOVE_UP : MOVE_DOWN;
        end
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        state_next     = state_reg;
        capacity_next  = capacity_reg;
        fiu_next       = fiu_reg;
        valid_next     = valid_reg;
        oc_next        = oc_reg;
        load_next      = load_reg;
        heading_next   = heading_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = rd_pend_reg;
        found_next     = found_reg;
        up_found_next  = up_found_reg;
        dn_found_next  = dn_found_reg;
        full_next      = full_reg;
        nres_next      = nres_reg;
        m_tvalid_next  = m_tvalid_reg;
        id_next        = id_reg;
        sf_next        = sf_reg;
        ef_next        = ef_reg;
        car_next       = car_reg;
        cur_next       = cur_reg;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_slot_next = best_slot_reg;
        best_age_next  = best_age_reg;
        up_d_next      = up_d_reg;
        dn_d_next      = dn_d_reg;
        m_kind_next    = m_kind_reg;
        m_id_next      = m_id_reg;
        m_elev_next    = m_elev_reg;
        m_move_next    = m_move_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        start_scan     = 1'b0;

        // A result leaves the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAPACITY: capacity_next = cfg_wdata[3:0];
                REG_FLOORS:   fiu_next      = cfg_wdata;
                default:      ;
            endcase
        end

        // Slot address walk shared by the drop, pick and direction searches.
        if (state_reg == ST_DROP_SCAN || state_reg == ST_PICK_SCAN ||
            state_reg == ST_DIR_SCAN) begin
            rd_pend_next = issuing;
            rd_idx_next  = scan_cnt_reg[IW-1:0];
            if (issuing) begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next       = s_tdata[15:0];
                    sf_next       = s_tdata[20:16];
                    ef_next       = s_tdata[25:21];
                    car_next      = s_tdata[28:26];
                    cur_next      = s_tdata[33:29];
                    nres_next     = '0;
                    start_scan    = 1'b1;
                    state_next    = (s_tuser == CMD_REGISTER) ? ST_REG_SCAN : ST_DROP_SCAN;
                end
            end
            ST_REG_SCAN: begin
                // Walk the valid bits for the lowest free slot.
                if (issuing) begin
                    if (!valid_reg[scan_cnt_reg[IW-1:0]]) begin
                        ram_we           = 1'b1;
                        ram_waddr        = scan_cnt_reg[IW-1:0];
                        ram_wdata.order  = oc_reg;
                        ram_wdata.aboard = 1'b0;
                        ram_wdata.car    = car_reg;
                        ram_wdata.target = ef_reg;
                        ram_wdata.origin = sf_reg;
                        ram_wdata.ident  = id_reg;
                        valid_next[scan_cnt_reg[IW-1:0]] = 1'b1;
                        oc_next          = oc_reg + 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_FULL_OUT;
                end
            end
            ST_FULL_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_FULL;
                    m_id_next     = id_reg;
                    m_elev_next   = car_reg;
                    m_move_next   = MOVE_STAY;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DROP_SCAN, ST_PICK_SCAN: begin
                // Keep the newest matching slot; equal ages keep the lower slot.
                if (rd_pend_reg && better) begin
                    found_next     = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_slot_next = rd_slot;
                    best_age_next  = age;
                end
                if (scan_done) begin
                    if (found_reg) begin
                        state_next = (state_reg == ST_DROP_SCAN) ? ST_DROP_OUT : ST_PICK_OUT;
                    end else if (state_reg == ST_DROP_SCAN) begin
                        state_next = ST_PICK_CHECK;
                    end else begin
                        full_next  = (car_load >= cap_eff);
                        start_scan = 1'b1;
                        state_next = ST_DIR_SCAN;
                    end
                end
            end
            ST_DROP_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_DROP;
                    m_id_next     = best_slot_reg.ident;
                    m_elev_next   = car_reg;
                    m_move_next   = MOVE_STAY;
                    m_last_next   = 1'b0;
                    valid_next[best_idx_reg] = 1'b0;
                    if (car_load != 4'd0) begin
                        load_next[car_reg] = car_load - 1'b1;
                    end
                    nres_next = nres_reg + 1'b1;
                    if (nres_next < 5'(CAP_LIMIT)) begin
                        start_scan = 1'b1;
                        state_next = ST_DROP_SCAN;
                    end else begin
                        state_next = ST_PICK_CHECK;
                    end
                end
            end
            ST_PICK_CHECK: begin
                start_scan = 1'b1;
                if (car_load < cap_eff && nres_reg < 5'd16) begin
                    state_next = ST_PICK_SCAN;
                end else begin
                    full_next  = (car_load >= cap_eff);
                    state_next = ST_DIR_SCAN;
                end
            end
            ST_PICK_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_PICK;
                    m_id_next     = best_slot_reg.ident;
                    m_elev_next   = car_reg;
                    m_move_next   = MOVE_STAY;
                    m_last_next   = 1'b0;
                    ram_we           = 1'b1;
                    ram_waddr        = best_idx_reg;
                    ram_wdata        = best_slot_reg;
                    ram_wdata.aboard = 1'b1;
                    ram_wdata.order  = oc_reg;
                    oc_next          = oc_reg + 1'b1;
                    load_next[car_reg] = car_load + 1'b1;
                    nres_next        = nres_reg + 1'b1;
                    state_next       = ST_PICK_CHECK;
                end
            end
            ST_DIR_SCAN: begin
                // Track the nearest pending stop above and below.
                if (rd_pend_reg) begin
                    if (cand_up && (!up_found_reg || cand_up_d < up_d_reg)) begin
                        up_found_next = 1'b1;
                        up_d_next     = cand_up_d;
                    end
                    if (cand_dn && (!dn_found_reg || cand_dn_d < dn_d_reg)) begin
                        dn_found_next = 1'b1;
                        dn_d_next     = cand_dn_d;
                    end
                end
                if (scan_done) begin
                    state_next = ST_DIR_OUT;
                end
            end
            ST_DIR_OUT: begin
                if (out_free) begin
                    heading_next[car_reg] = new_heading;
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_DIR;
                    m_id_next     = '0;
                    m_elev_next   = car_reg;
                    m_move_next   = new_heading;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Restart the shared search.
        if (start_scan) begin
            scan_cnt_next = '0;
            rd_pend_next  = 1'b0;
            found_next    = 1'b0;
            up_found_next = 1'b0;
            dn_found_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            fiu_reg      <= FIU_RESET;
            valid_reg    <= '0;
            oc_reg       <= '0;
            for (int e = 0; e < ELEVATORS; e++) begin
                load_reg[e]    <= '0;
                heading_reg[e] <= MOVE_STAY;
            end
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
            up_found_reg <= 1'b0;
            dn_found_reg <= 1'b0;
            full_reg     <= 1'b0;
            nres_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            fiu_reg      <= fiu_next;
            valid_reg    <= valid_next;
            oc_reg       <= oc_next;
            load_reg     <= load_next;
            heading_reg  <= heading_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            found_reg    <= found_next;
            up_found_reg <= up_found_next;
            dn_found_reg <= dn_found_next;
            full_reg     <= full_next;
            nres_reg     <= nres_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        sf_reg        <= sf_next;
        ef_reg        <= ef_next;
        car_reg       <= car_next;
        cur_reg       <= cur_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_slot_reg <= best_slot_next;
        best_age_reg  <= best_age_next;
        up_d_reg      <= up_d_next;
        dn_d_reg      <= dn_d_next;
        m_kind_reg    <= m_kind_next;
        m_id_reg      <= m_id_next;
        m_elev_reg    <= m_elev_next;
        m_move_reg    <= m_move_next;
        m_last_reg    <= m_last_next;
    end

endmodule

/* hdl/esc_checker.sv */
module esc_checker
    import esc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only direction and table full results close a transfer's results.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == KIND_DIR || m_tuser == KIND_FULL))
        else $error("tlast on a drop or pick result");

    // Direction and table full results always carry tlast.
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DIR || m_tuser == KIND_FULL) |-> m_tlast)
        else $error("final result without tlast");

    // A direction result carries no passenger and a legal move.
    a_dir_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DIR |-> m_tdata[15:0] == 16'd0 && m_tdata[20:19] != 2'd3)
        else $error("bad direction result fields");

    // The block is busy right after it takes an input transfer.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an input transfer");

endmodule

bind elevator_stop_scheduler esc_checker u_esc_checker (.*);

/* dv/tb_top.sv */
module tb_top;
    import esc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    // One result as it leaves the block.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [2:0]  car;
        logic [1:0]  mv;
        logic        last;
    } result_t;

    // One row of the directed stimulus; typed rows carry their own expected direction.
    typedef struct {
        logic        cmd;
        logic [15:0] id;
        logic [4:0]  sf;
        logic [4:0]  ef;
        logic [2:0]  car;
        logic [4:0]  cur;
        bit          typed;
        logic [1:0]  mv;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_CAPACITY;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = CMD_REGISTER;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    elevator_stop_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the request table and the per-elevator state.
    bit          tbl_valid [TABLE_SLOTS];
    logic [15:0] tbl_ident [TABLE_SLOTS];
    logic [4:0]  tbl_origin [TABLE_SLOTS];
    logic [4:0]  tbl_target [TABLE_SLOTS];
    logic [2:0]  tbl_car [TABLE_SLOTS];
    bit          tbl_aboard [TABLE_SLOTS];
    logic [15:0] tbl_stamp [TABLE_SLOTS];
    logic [15:0] stamp_ctr;
    logic [3:0]  car_load [ELEVATORS];
    logic [1:0]  car_heading [ELEVATORS];
    logic [3:0]  cap_reg;
    logic [5:0]  fiu_reg;

    result_t expected_results[$];
    int      errors = 0;
    int      s_idle_pct = 0;
    int      m_idle_pct = 0;

    function automatic void push_result(logic [1:0] kind, logic [15:0] pid, logic [2:0] car,
                                        logic [1:0] mv, logic last);
        result_t r;
        r.kind = kind;
        r.pid = pid;
        r.car = car;
        r.mv = mv;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // Newest slot of this car waiting at (or riding to) the floor; ties go to the lower slot.
    function automatic int newest_slot(logic [2:0] car, logic [4:0] floor, bit aboard);
        int best;
        logic [15:0] best_age;
        logic [15:0] age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_valid[i] && tbl_car[i] == car && tbl_aboard[i] == aboard &&
                (aboard ? tbl_target[i] : tbl_origin[i]) == floor) begin
                age = stamp_ctr - tbl_stamp[i];
                if (best < 0 || age < best_age) begin
                    best = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    function automatic bit stop_pending(logic [2:0] car, int floor, bit full);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_valid[i] && tbl_car[i] == car) begin
                if (tbl_aboard[i] && tbl_target[i] == floor) return 1'b1;
                if (!full && !tbl_aboard[i] && tbl_origin[i] == floor) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted transfer to the shadow state and queues its results.
    function automatic void schedule_stops(logic cmd, logic [15:0] id, logic [4:0] sf,
                                           logic [4:0] ef, logic [2:0] car, logic [4:0] cur);
        int n;
        int s;
        int cap;
        int lim;
        int up_d;
        int down_d;
        bit full;
        bit up;
        bit down;
        n = 0;
        up = 0;
        down = 0;
        up_d = 0;
        down_d = 0;
        if (cmd == CMD_REGISTER) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (!tbl_valid[i]) begin
                    tbl_valid[i] = 1'b1;
                    tbl_ident[i] = id;
                    tbl_origin[i] = sf;
                    tbl_target[i] = ef;
                    tbl_car[i] = car;
                    tbl_aboard[i] = 1'b0;
                    tbl_stamp[i] = stamp_ctr;
                    stamp_ctr++;
                    return;
                end
            end
            push_result(KIND_FULL, id, car, MOVE_STAY, 1'b1);
            return;
        end
        cap = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
        // Riders leave first, most recently picked first.
        while (n < CAP_LIMIT) begin
            s = newest_slot(car, cur, 1'b1);
            if (s < 0) break;
            push_result(KIND_DROP, tbl_ident[s], car, MOVE_STAY, 1'b0);
            n++;
            tbl_valid[s] = 1'b0;
            if (car_load[car] > 0) car_load[car]--;
        end
        // Then waiters board, newest first, while there is room.
        while (car_load[car] < cap && n < 2 * CAP_LIMIT) begin
            s = newest_slot(car, cur, 1'b0);
            if (s < 0) break;
            push_result(KIND_PICK, tbl_ident[s], car, MOVE_STAY, 1'b0);
            n++;
            tbl_aboard[s] = 1'b1;
            tbl_stamp[s] = stamp_ctr;
            stamp_ctr++;
            car_load[car]++;
        end
        // Direction: look for the nearest pending stop on each side.
        full = car_load[car] >= cap;
        lim = (fiu_reg > FLOORS) ? FLOORS : fiu_reg;
        for (int j = cur + 1; j < lim; j++) begin
            if (stop_pending(car, j, full)) begin
                up = 1'b1;
                up_d = j - cur;
                break;
            end
        end
        for (int j = cur - 1; j >= 0; j--) begin
            if (stop_pending(car, j, full)) begin
                down = 1'b1;
                down_d = cur - j;
                break;
            end
        end
        if (!up && !down) car_heading[car] = MOVE_STAY;
        else if (up && !down) car_heading[car] = MOVE_UP;
        else if (!up && down) car_heading[car] = MOVE_DOWN;
        else if (car_heading[car] != MOVE_UP && car_heading[car] != MOVE_DOWN)
            car_heading[car] = (up_d <= down_d) ? MOVE_UP : MOVE_DOWN;
        push_result(KIND_DIR, 16'h0000, car, car_heading[car], 1'b1);
    endfunction

    // Sends one input transfer, sometimes after a random idle gap, and predicts it once accepted.
    task automatic send_item(logic cmd, logic [15:0] id, logic [4:0] sf, logic [4:0] ef,
                             logic [2:0] car, logic [4:0] cur, bit typed = 0,
                             logic [1:0] mv = MOVE_STAY);
        if ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'b0, cur, car, ef, sf, id};
        do @(posedge aclk); while (!s_tready);
        schedule_stops(cmd, id, sf, ef, car, cur);
        // A typed row replaces the predicted direction result with its own.
        if (typed) begin
            void'(expected_results.pop_back());
            push_result(KIND_DIR, 16'h0000, car, mv, 1'b1);
        end
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic write_config(logic [3:0] cap, logic [5:0] fiu);
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_wdata <= {2'b00, cap};
        @(posedge aclk);
        cfg_index <= REG_FLOORS;
        cfg_wdata <= fiu;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = cap;
        fiu_reg = fiu;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // A random transfer that mostly registers requests or serves a floor with work pending.
    task automatic random_item();
        int s;
        logic [4:0] fl;
        logic [2:0] car;
        s = -1;
        car = 3'($urandom_range(7));
        fl = ($urandom_range(1)) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
        if ($urandom_range(99) < 50) begin
            send_item(CMD_REGISTER, 16'($urandom), fl, 5'($urandom_range(31)), car,
                      5'($urandom));
        end else begin
            if ($urandom_range(99) < 80) begin
                for (int k = 0, b = $urandom_range(TABLE_SLOTS - 1); k < TABLE_SLOTS; k++) begin
                    if (tbl_valid[(b + k) % TABLE_SLOTS]) begin
                        s = (b + k) % TABLE_SLOTS;
                        break;
                    end
                end
            end
            if (s >= 0) begin
                car = tbl_car[s];
                fl = tbl_aboard[s] ? tbl_target[s] : tbl_origin[s];
            end
            send_item(CMD_TURN, 16'($urandom), 5'($urandom), 5'($urandom), car, fl);
        end
    endtask

    // Result channel: random back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind %0d id %h", m_tuser, m_tdata[15:0]);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("result_kind expected %0d actual %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== e.pid) begin
                    $error("passenger_id expected %h actual %h", e.pid, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[18:16] !== e.car) begin
                    $error("elevator_number expected %0d actual %0d", e.car, m_tdata[18:16]);
                    errors++;
                end
                if (m_tdata[20:19] !== e.mv) begin
                    $error("move expected %0d actual %0d", e.mv, m_tdata[20:19]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    row_t directed[] = '{
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd0, 5'd0,  1, MOVE_STAY},
        '{CMD_TURN,     16'hFFFF, 5'd31, 5'd31, 3'd7, 5'd31, 1, MOVE_STAY},
        '{CMD_REGISTER, 16'hFFFF, 5'd0,  5'd31, 3'd7, 5'd0,  0, MOVE_STAY},
        '{CMD_REGISTER, 16'h0000, 5'd31, 5'd0,  3'd7, 5'd0,  0, MOVE_STAY},
        '{CMD_REGISTER, 16'h1234, 5'd0,  5'd5,  3'd7, 5'd0,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd7, 5'd0,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd7, 5'd5,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd7, 5'd31, 0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd7, 5'd0,  0, MOVE_STAY},
        '{CMD_REGISTER, 16'hAAAA, 5'd10, 5'd20, 3'd3, 5'd0,  0, MOVE_STAY},
        '{CMD_REGISTER, 16'h5555, 5'd20, 5'd10, 3'd3, 5'd0,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd3, 5'd15, 0, MOVE_STAY},
        '{CMD_REGISTER, 16'h0F0F, 5'd14, 5'd2,  3'd3, 5'd0,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd3, 5'd16, 0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd3, 5'd10, 0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd3, 5'd20, 0, MOVE_STAY},
        '{CMD_REGISTER, 16'h8001, 5'd3,  5'd3,  3'd1, 5'd0,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd1, 5'd3,  0, MOVE_STAY},
        '{CMD_TURN,     16'h0000, 5'd0,  5'd0,  3'd1, 5'd3,  0, MOVE_STAY}
    };

    // Register settings per phase; the extremes and out-of-range values are included.
    logic [3:0] phase_cap[6] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd4};
    logic [5:0] phase_fiu[6] = '{6'd2, 6'd32, 6'd63, 6'd17, 6'd8, 6'd32};

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) tbl_valid[i] = 1'b0;
        for (int c = 0; c < ELEVATORS; c++) begin
            car_load[c] = '0;
            car_heading[c] = MOVE_STAY;
        end
        stamp_ctr = '0;
        cap_reg = CAP_RESET;
        fiu_reg = FIU_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings.
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].id, directed[i].sf, directed[i].ef,
                      directed[i].car, directed[i].cur, directed[i].typed, directed[i].mv);
        wait_idle();

        // Random part: three idling patterns, two register settings each.
        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin s_idle_pct = 26; m_idle_pct = 85; end
                1: begin s_idle_pct = 85; m_idle_pct = 26; end
                default: begin s_idle_pct = 0; m_idle_pct = 0; end
            endcase
            write_config(phase_cap[p], phase_fiu[p]);
            // One phase fills the table to force table-full results.
            if (p == 2) begin
                repeat (TABLE_SLOTS + 2)
                    send_item(CMD_REGISTER, 16'($urandom), 5'($urandom), 5'($urandom),
                              3'($urandom), 5'($urandom));
            end
            repeat (22) random_item();
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
